/* sv/bayer_gbrg_bilinear_demosaic_macros.svh */
// Assertion macros shared by the demosaic RTL.
// Needs clk and rst in scope where used; no other dependencies.
`ifndef BAYER_GBRG_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_GBRG_BILINEAR_DEMOSAIC_MACROS_SVH

// Same-cycle implication, held off during reset.
`define DMSC_ASSERT_IMPL(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (res)) else $error(msg);

// Next-cycle implication, held off during reset.
`define DMSC_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

/* sv/dmsc_pkg.sv */
// Shared types and constants of the GBRG bilinear demosaic.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dmsc_pkg;

  localparam int CFG_W  = 12;  // image_width / image_height register width
  localparam int ROW_W  = 12;  // row counters
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 10;  // up to four 8-bit samples
  localparam int CNT_W  = 3;   // up to four contributors

  localparam int MIN_DIM = 2;

  // Truncated divide by three: (sum * 683) >> 11 is exact for sums below 1024
  localparam int RECIP3_W     = 10;
  localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
  localparam int RECIP3_SHIFT = 11;

  // Front-to-back queue (depth must be a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  // Input request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_BLANK = 1'b1;

  // Colour sampled at a mosaic site, also used to name output channels
  typedef enum logic [1:0] {
    SITE_RED,
    SITE_GREEN,
    SITE_BLUE
  } dmsc_site_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;
  } dmsc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } dmsc_out_t;

  // Position class of the pixel being reconstructed
  typedef struct packed {
    dmsc_site_t site;
    logic       odd;
    logic       top;
    logic       bot;
    logic       lft;
    logic       rgt;
    logic       last;
  } dmsc_flags_t;

  // One window column plus the classification of the step
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pix;
    logic             emit;
    dmsc_flags_t      flags;
  } dmsc_qent_t;

  // Neighbour sum and count for one channel
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } dmsc_acc_t;

endpackage

/* sv/dmsc_queue.sv */
// Short register queue between the demosaic front and back.
// Depends on dmsc_pkg (entry type, depth) and the assertion macros.
`timescale 1ns / 1ps
`include "bayer_gbrg_bilinear_demosaic_macros.svh"

module dmsc_queue import dmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dmsc_qent_t        data_in,
  input  logic              pop,
  output logic              valid,
  output dmsc_qent_t        data_out,
  output logic [QCNT_W-1:0] count
);

  dmsc_qent_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  // Pointers and fill level; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign valid    = (count != '0);
  assign data_out = slots[rd_ptr];

  `DMSC_ASSERT_IMPL(a_no_overflow, push && !pop, count != QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `DMSC_ASSERT_IMPL(a_no_underflow, pop, count != '0, "pop from empty queue")

endmodule

/* sv/dmsc_front.sv */
// Demosaic front: takes raw samples, keeps the two line stores and all
// position counters, and classifies each step. Depends on dmsc_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "bayer_gbrg_bilinear_demosaic_macros.svh"

module dmsc_front import dmsc_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dmsc_in_t          item,
  input  logic [CFG_W-1:0]  image_width,
  input  logic [CFG_W-1:0]  image_height,
  output logic              q_push,
  output dmsc_qent_t        q_data,
  input  logic [QCNT_W-1:0] q_count
);

  localparam int IW   = $clog2(MAX_WIDTH);
  localparam int CMPW = ((IW > CFG_W) ? IW : CFG_W) + 1;
  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

  // Line stores: previous row and the row before it
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;

  // Position counters
  logic [IW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [IW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;
  logic [IW-1:0]    in_col_next;
  logic [ROW_W-1:0] in_row_next;
  logic [IW-1:0]    out_col_next;
  logic [ROW_W-1:0] out_row_next;

  // Second stage, waiting for line-store read data
  logic             s1_valid;
  logic             s1_wr;
  logic [IW-1:0]    s1_idx;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_emit;
  dmsc_flags_t      s1_flags;

  logic [CMPW-1:0]  w_ext;
  logic [CMPW-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             accept;
  logic             draining;
  logic             proc;
  logic             emit;
  logic [CMPW-1:0]  col_inc;
  logic             col_wrap;
  logic [CMPW-1:0]  ocol_inc;
  logic             ocol_wrap;
  dmsc_flags_t      flags;

  // Effective frame size, clamped
  always_comb begin
    w_ext = CMPW'(image_width);
    if (w_ext < CMPW'(MIN_DIM))   eff_w = CMPW'(MIN_DIM);
    else if (w_ext > MAXW_C)      eff_w = MAXW_C;
    else                          eff_w = w_ext;
    eff_h = (image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height;
  end

  assign full   = (QCNT_W'(q_count) + QCNT_W'(s1_valid)) >= QCNT_W'(QUEUE_DEPTH);
  assign accept = push && !full;

  // Classify the step
  always_comb begin
    draining = (in_row >= eff_h);
    proc     = accept && (draining || (item.req_type != REQ_BLANK));
    emit     = draining || (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
    col_inc  = CMPW'(in_col) + CMPW'(1);
    col_wrap = (col_inc >= eff_w);
    ocol_inc  = CMPW'(out_col) + CMPW'(1);
    ocol_wrap = (ocol_inc >= eff_w);

    flags.odd  = out_row[0];
    if (!out_row[0]) flags.site = out_col[0] ? SITE_BLUE  : SITE_GREEN;
    else             flags.site = out_col[0] ? SITE_GREEN : SITE_RED;
    flags.top  = (out_row == '0);
    flags.bot  = ({1'b0, out_row} + (ROW_W + 1)'(1)) >= {1'b0, eff_h};
    flags.lft  = (out_col == '0);
    flags.rgt  = ocol_wrap;
    flags.last = flags.bot && flags.rgt;
  end

  // Counter update; the last pixel of a frame restarts everything
  always_comb begin
    in_col_next  = col_wrap ? '0 : col_inc[IW-1:0];
    in_row_next  = (col_wrap && !draining) ? in_row + ROW_W'(1) : in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit) begin
      if (flags.last) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else begin
        out_col_next = ocol_wrap ? '0 : ocol_inc[IW-1:0];
        out_row_next = ocol_wrap ? out_row + ROW_W'(1) : out_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= proc;
      if (proc) begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        out_col <= out_col_next;
        out_row <= out_row_next;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (proc) begin
      s1_wr    <= !draining;
      s1_idx   <= in_col;
      s1_pix   <= draining ? '0 : item.pixel_value;
      s1_emit  <= emit;
      s1_flags <= flags;
    end
  end

  // Middle store: read old entry, replace with the new sample
  always_ff @(posedge clk) begin
    if (proc) begin
      mid_rd <= middle_mem[in_col];
      if (!draining) middle_mem[in_col] <= item.pixel_value;
    end
  end

  // Upper store: read now, take the displaced middle entry in the next cycle
  always_ff @(posedge clk) begin
    if (proc) begin
      up_rd <= upper_mem[in_col];
    end
    if (s1_valid && s1_wr) begin
      upper_mem[s1_idx] <= mid_rd;
    end
  end

  // Hand the window column to the back
  assign q_push       = s1_valid;
  assign q_data.up    = up_rd;
  assign q_data.mid   = mid_rd;
  assign q_data.pix   = s1_pix;
  assign q_data.emit  = s1_emit;
  assign q_data.flags = s1_flags;

  `DMSC_ASSERT_IMPL(a_s1_room, s1_valid, q_count < QCNT_W'(QUEUE_DEPTH), "front stage has no queue slot")
  `DMSC_ASSERT_NEXT(a_last_clears, proc && emit && flags.last, (in_col == '0) && (in_row == '0) && (out_col == '0) && (out_row == '0), "counters not cleared after frame end")

endmodule

/* sv/dmsc_back.sv */
// Demosaic back: 3x3 neighbour window, per-channel neighbour sums and the
// truncated means, with the result register. Depends on dmsc_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "bayer_gbrg_bilinear_demosaic_macros.svh"

module dmsc_back import dmsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  dmsc_qent_t q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output dmsc_out_t  result
);

  // Window, row-major: 0..2 oldest row, 6..8 newest row; column 2 newest
  logic [8:0][PIX_W-1:0] win;
  logic [8:0][PIX_W-1:0] win_next;

  logic      a_valid;
  dmsc_acc_t a_red;
  dmsc_acc_t a_green;
  dmsc_acc_t a_blue;
  logic      a_last;
  logic      a_ready;
  logic      out_valid;
  logic      out_load;

  // Sum and count of the neighbours that feed one channel
  function automatic dmsc_acc_t chan_acc(input dmsc_site_t ch, input dmsc_flags_t f,
                                         input logic [8:0][PIX_W-1:0] w);
    dmsc_acc_t acc;
    logic      horiz;
    acc   = '0;
    horiz = (!f.odd && (ch == SITE_BLUE)) || (f.odd && (ch == SITE_RED));
    if (ch == f.site) begin
      acc.sum = SUM_W'(w[4]);
      acc.cnt = CNT_W'(1);
    end else if (ch == SITE_GREEN) begin
      // cross neighbours
      acc.sum = (f.top ? '0 : SUM_W'(w[1])) + (f.bot ? '0 : SUM_W'(w[7]))
              + (f.lft ? '0 : SUM_W'(w[3])) + (f.rgt ? '0 : SUM_W'(w[5]));
      acc.cnt = CNT_W'(!f.top) + CNT_W'(!f.bot) + CNT_W'(!f.lft) + CNT_W'(!f.rgt);
    end else if (f.site != SITE_GREEN) begin
      // diagonals
      acc.sum = ((f.top || f.lft) ? '0 : SUM_W'(w[0])) + ((f.top || f.rgt) ? '0 : SUM_W'(w[2]))
              + ((f.bot || f.lft) ? '0 : SUM_W'(w[6])) + ((f.bot || f.rgt) ? '0 : SUM_W'(w[8]));
      acc.cnt = CNT_W'(!(f.top || f.lft)) + CNT_W'(!(f.top || f.rgt))
              + CNT_W'(!(f.bot || f.lft)) + CNT_W'(!(f.bot || f.rgt));
    end else if (horiz) begin
      acc.sum = (f.lft ? '0 : SUM_W'(w[3])) + (f.rgt ? '0 : SUM_W'(w[5]));
      acc.cnt = CNT_W'(!f.lft) + CNT_W'(!f.rgt);
    end else begin
      acc.sum = (f.top ? '0 : SUM_W'(w[1])) + (f.bot ? '0 : SUM_W'(w[7]));
      acc.cnt = CNT_W'(!f.top) + CNT_W'(!f.bot);
    end
    return acc;
  endfunction

  // Truncated mean of one to four samples
  function automatic logic [PIX_W-1:0] acc_mean(input dmsc_acc_t acc);
    logic [SUM_W+RECIP3_W-1:0] prod;
    logic [PIX_W-1:0]          mean;
    prod = (SUM_W + RECIP3_W)'(acc.sum) * (SUM_W + RECIP3_W)'(RECIP3);
    unique case (acc.cnt)
      CNT_W'(1): mean = acc.sum[PIX_W-1:0];
      CNT_W'(2): mean = acc.sum[PIX_W:1];
      CNT_W'(3): mean = prod[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
      CNT_W'(4): mean = acc.sum[PIX_W+1:2];
      default:   mean = '0;
    endcase
    return mean;
  endfunction

  // Handshake through the two back stages
  assign out_load = a_valid && (!out_valid || pop);
  assign a_ready  = !a_valid || out_load;
  assign q_pop    = q_valid && a_ready;
  assign empty    = !out_valid;

  // Window shift with the new column from the queue
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3 + 1];
      win_next[r*3 + 1] = win[r*3 + 2];
    end
    win_next[2] = q_head.up;
    win_next[5] = q_head.mid;
    win_next[8] = q_head.pix;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win <= win_next;
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop && q_head.emit) begin
      a_valid <= 1'b1;
    end else if (out_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.emit) begin
      a_red   <= chan_acc(SITE_RED,   q_head.flags, win_next);
      a_green <= chan_acc(SITE_GREEN, q_head.flags, win_next);
      a_blue  <= chan_acc(SITE_BLUE,  q_head.flags, win_next);
      a_last  <= q_head.flags.last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.red       <= acc_mean(a_red);
      result.green     <= acc_mean(a_green);
      result.blue      <= acc_mean(a_blue);
      result.frame_end <= a_last;
    end
  end

  `DMSC_ASSERT_IMPL(a_cnt_nonzero, a_valid, (a_red.cnt != '0) && (a_green.cnt != '0) && (a_blue.cnt != '0), "empty neighbour set")

endmodule

/* sv/bayer_gbrg_bilinear_demosaic.sv */
// Bilinear GBRG demosaic. Raw 8-bit samples enter in raster order through a
// push/full queue port; RGB pixels leave through an empty/pop queue port, one
// per input step once the image has filled one row plus one pixel. A new item
// is taken every clock while full is low: the front does one read and one
// write of each line store per item and the back reduces one window per
// cycle, so sustained rate is one item per cycle while results are popped.
// full also rises when results are not popped and the internal
// queue backs up. After the last raw pixel of a frame, blanking ticks (or
// pixels, which are then dropped) drain the final row; frame_end marks the
// last pixel, after which a new frame may begin. Image width and height are
// set through the APB port (width at 0x0, height at 0x4) and clamp to
// [2, MAX_WIDTH] and at least 2. Line stores hold MAX_WIDTH bytes each and
// need no clearing after reset.
// Depends on dmsc_pkg, dmsc_front, dmsc_queue and dmsc_back.
`timescale 1ns / 1ps

module bayer_gbrg_bilinear_demosaic import dmsc_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  dmsc_in_t              item,
  output logic                  empty,
  input  logic                  pop,
  output dmsc_out_t             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic              cfg_wr;
  logic              q_push;
  dmsc_qent_t        q_in;
  logic              q_pop;
  logic              q_valid;
  dmsc_qent_t        q_head;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Front: line stores and classification
  dmsc_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .image_width (image_width),
    .image_height(image_height),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_count     (q_count)
  );

  // Decoupling queue
  dmsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .data_in (q_in),
    .pop     (q_pop),
    .valid   (q_valid),
    .data_out(q_head),
    .count   (q_count)
  );

  // Back: window and interpolation
  dmsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

/* test/testbench.sv */
// Self-checking bench for the GBRG bilinear demosaic: raster frames in, RGB pixels out.
// A scoreboard class predicts every pixel; plain tasks drive the input queue and APB ports.
// Depends on dmsc_pkg and bayer_gbrg_bilinear_demosaic.
`timescale 1ns / 1ps

module testbench;
  import dmsc_pkg::*;

  localparam int LINE_MAX      = 2048;
  localparam int ITEM_TARGET   = 600;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 150;  // long result back-pressure stretch
  localparam int STALL_LIMIT   = 2000;
  localparam int PRESSURE_FRAME = 3;

  // Pixel predictor and store of expected RGB transfers
  class rgb_scoreboard;
    logic [PIX_W-1:0] upper_row [LINE_MAX];
    logic [PIX_W-1:0] middle_row[LINE_MAX];
    logic [PIX_W-1:0] nb[9];  // 3x3 neighborhood, row-major, top row first
    int unsigned in_col, in_row, out_col, out_row;
    logic [CFG_W-1:0] width_reg, height_reg;
    int unsigned acc_sum, acc_cnt;
    int errors, checked;
    dmsc_out_t rgb_expected[$];

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      foreach (nb[i]) nb[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      width_reg = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int unsigned width_now();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned height_now();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    // All raw pixels of the frame are in; the last row is being flushed
    function bit draining();
      return in_row >= height_now();
    endfunction

    function int pending();
      return rgb_expected.size();
    endfunction

    function void gather(bit ok, logic [PIX_W-1:0] v);
      if (ok) begin
        acc_sum += v;
        acc_cnt++;
      end
    endfunction

    // Truncated mean of the in-image neighbors that supply one channel
    function logic [PIX_W-1:0] estimate(dmsc_site_t ch, dmsc_site_t site, bit odd,
                                        bit top, bit bot, bit lft, bit rgt);
      acc_sum = 0;
      acc_cnt = 0;
      if (ch == site) return nb[4];
      if (ch == SITE_GREEN) begin
        gather(!top, nb[1]);
        gather(!bot, nb[7]);
        gather(!lft, nb[3]);
        gather(!rgt, nb[5]);
      end else if (site != SITE_GREEN) begin
        gather(!top && !lft, nb[0]);
        gather(!top && !rgt, nb[2]);
        gather(!bot && !lft, nb[6]);
        gather(!bot && !rgt, nb[8]);
      end else if ((!odd && ch == SITE_BLUE) || (odd && ch == SITE_RED)) begin
        gather(!lft, nb[3]);
        gather(!rgt, nb[5]);
      end else begin
        gather(!top, nb[1]);
        gather(!bot, nb[7]);
      end
      return (acc_cnt == 0) ? '0 : PIX_W'(acc_sum / acc_cnt);
    endfunction

    // Advance the line stores and window by one accepted input transfer
    function void predict_pixel(dmsc_in_t x);
      int unsigned w, h, col;
      int r;
      bit drain, fires, odd, top, bot, lft, rgt;
      logic [PIX_W-1:0] up, mid;
      dmsc_site_t site;
      dmsc_out_t px;
      w = width_now();
      h = height_now();
      drain = in_row >= h;
      // blanking inside a frame is a no-op
      if (!drain && x.req_type == REQ_BLANK) return;
      col = in_col % LINE_MAX;
      up = upper_row[col];
      mid = middle_row[col];
      for (r = 0; r < 3; r++) begin
        nb[r*3]   = nb[r*3+1];
        nb[r*3+1] = nb[r*3+2];
      end
      nb[2] = up;
      nb[5] = mid;
      nb[8] = drain ? '0 : x.pixel_value;
      if (!drain) begin
        upper_row[col] = mid;
        middle_row[col] = x.pixel_value;
        fires = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      end else begin
        fires = 1'b1;
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        if (!drain) in_row++;
      end
      if (!fires) return;

      odd = out_row[0];
      if (!odd) site = out_col[0] ? SITE_BLUE : SITE_GREEN;
      else site = out_col[0] ? SITE_GREEN : SITE_RED;
      top = (out_row == 0);
      bot = (out_row + 1 >= h);
      lft = (out_col == 0);
      rgt = (out_col + 1 >= w);
      px.red = estimate(SITE_RED, site, odd, top, bot, lft, rgt);
      px.green = estimate(SITE_GREEN, site, odd, top, bot, lft, rgt);
      px.blue = estimate(SITE_BLUE, site, odd, top, bot, lft, rgt);
      px.frame_end = bot && rgt;
      rgb_expected.push_back(px);

      if (px.frame_end) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void report(string field, int want, int got);
      if (errors < 200)
        $display("%0t: %s mismatch on pixel %0d: expected %0d, actual %0d",
                 $time, field, checked, want, got);
      errors++;
    endfunction

    // Compare one accepted output transfer with the oldest prediction
    function void match_pixel(dmsc_out_t got);
      dmsc_out_t want;
      if (rgb_expected.size() == 0) begin
        report("unexpected pixel (red)", -1, got.red);
        return;
      end
      want = rgb_expected.pop_front();
      checked++;
      if (got.red !== want.red) report("red", want.red, got.red);
      if (got.green !== want.green) report("green", want.green, got.green);
      if (got.blue !== want.blue) report("blue", want.blue, got.blue);
      if (got.frame_end !== want.frame_end) report("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  dmsc_in_t              item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  dmsc_out_t             result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rgb_scoreboard pixel_sb = new();
  bit quiet_tx, quiet_rx;
  int hold_cycles, long_holds, counted, frames_done, reg_writes, quiet_cycles;

  bayer_gbrg_bilinear_demosaic #(
    .MAX_WIDTH(LINE_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one input transfer, after a random gap unless quiet_tx is set, and wait until it is taken
  task automatic push_sample(input logic kind, input logic [PIX_W-1:0] value);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{req_type: kind, pixel_value: value};
    @(posedge clk);
    while (full) @(posedge clk);
    pixel_sb.predict_pixel('{req_type: kind, pixel_value: value});
  endtask

  // Let every expected pixel arrive and the pipeline go quiet
  task automatic settle();
    push <= 1'b0;
    while (pixel_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Optional APB write, always followed by a read-back check
  task automatic reg_access(input logic idx, input bit wr, input logic [CFG_W-1:0] val);
    logic [APB_DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    if (wr) begin
      pwrite <= 1'b1;
      pwdata <= APB_DATA_W'({$urandom, val});  // junk above the register width
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      penable <= 1'b0;
      pixel_sb.set_reg(idx, val);
      reg_writes++;
    end
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = '0;
    want[CFG_W-1:0] = (idx == REG_IMAGE_WIDTH) ? pixel_sb.width_reg : pixel_sb.height_reg;
    if (prdata !== want) begin
      $display("%0t: register %0d read: expected %0d, actual %0d", $time, idx, want, prdata);
      pixel_sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One raster frame with stray blanking and an optional height change, then a mixed flush of the last row
  task automatic run_frame(input int cut_at, input int hold_at, input logic [CFG_W-1:0] cut_h);
    int n;
    n = 0;
    while (!pixel_sb.draining()) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(REQ_BLANK, PIX_W'($urandom));
      end else begin
        push_sample(REQ_PIXEL, PIX_W'($urandom));
        n++;
        counted++;
        if (n == hold_at) hold_cycles = HOLD_CYCLES;
        if (n == cut_at) begin
          settle();
          reg_access(REG_IMAGE_HEIGHT, 1'b1, cut_h);
        end
      end
    end
    while (pixel_sb.draining()) begin
      push_sample(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_BLANK, PIX_W'($urandom));
      counted++;
    end
    frames_done++;
  endtask

  // Result side: random stalls, quiet stretches, one long hold on request
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
        long_holds++;
      end else begin
        if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
        stall = quiet_rx ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      pixel_sb.match_pixel(result);
    end
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w, h;
    int cut_at, hold_at;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values of both registers
    reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
    reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);

    // sizes below range clamp to a 2x2 frame; blank mid-frame, pixel while flushing
    reg_access(REG_IMAGE_WIDTH, 1'b1, 12'd1);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 12'd0);
    push_sample(REQ_PIXEL, 8'h00);
    push_sample(REQ_BLANK, 8'hFF);
    push_sample(REQ_PIXEL, 8'hFF);
    push_sample(REQ_PIXEL, 8'hFF);
    push_sample(REQ_PIXEL, 8'h00);
    push_sample(REQ_BLANK, 8'h00);
    push_sample(REQ_PIXEL, 8'hA5);
    push_sample(REQ_BLANK, 8'h5A);
    counted += 7;

    // width above range clamps to the line store size, height at its maximum;
    // then both registers change mid-frame
    settle();
    reg_access(REG_IMAGE_WIDTH, 1'b1, 12'd4095);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 12'd4095);
    push_sample(REQ_PIXEL, 8'hFF);
    push_sample(REQ_PIXEL, 8'h00);
    push_sample(REQ_PIXEL, 8'hFF);
    push_sample(REQ_PIXEL, 8'h00);
    push_sample(REQ_PIXEL, 8'h80);
    settle();
    reg_access(REG_IMAGE_WIDTH, 1'b1, 12'd3);
    push_sample(REQ_PIXEL, 8'h01);
    push_sample(REQ_PIXEL, 8'hFE);
    push_sample(REQ_PIXEL, 8'h7F);
    push_sample(REQ_PIXEL, 8'hFF);
    push_sample(REQ_PIXEL, 8'h00);
    push_sample(REQ_PIXEL, 8'hC3);
    push_sample(REQ_PIXEL, 8'h3C);
    counted += 12;
    settle();
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 12'd1);
    while (pixel_sb.draining()) begin
      push_sample(REQ_BLANK, 8'h00);
      counted++;
    end

    // random frames, resized only while the block is idle
    while (counted < ITEM_TARGET) begin
      cut_at = 0;
      hold_at = 0;
      if (frames_done == PRESSURE_FRAME) begin
        w = 12'd8;
        h = 12'd8;
        hold_at = 10;
        settle();
        reg_access(REG_IMAGE_WIDTH, 1'b1, w);
        reg_access(REG_IMAGE_HEIGHT, 1'b1, h);
      end else if (frames_done == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, 1);
          1, 2:    w = $urandom_range(13, 24);
          default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 9))
          0:       h = $urandom_range(0, 1);
          1:       h = $urandom_range(9, 12);
          default: h = $urandom_range(2, 8);
        endcase
        settle();
        reg_access(REG_IMAGE_WIDTH, 1'b1, w);
        reg_access(REG_IMAGE_HEIGHT, 1'b1, h);
      end
      if ($urandom_range(0, 7) == 0) cut_at = $urandom_range(1, 20);
      quiet_tx = (hold_at != 0) || ($urandom_range(0, 3) == 0);
      run_frame(cut_at, hold_at, $urandom_range(0, 8));
    end

    settle();
    $display("Covered %0d input transfers over %0d random frames, %0d pixels checked,",
             counted, frames_done, pixel_sb.checked);
    $display("%0d register writes, %0d long output hold(s)", reg_writes, long_holds);
    if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/dmsc_pkg.sv
sv/dmsc_queue.sv
sv/dmsc_front.sv
sv/dmsc_back.sv
sv/bayer_gbrg_bilinear_demosaic.sv
test/testbench.sv
